/* src/sll_pkg.sv */
package sll_pkg;

	localparam int CAPACITY = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int OP_W     = 3;
	localparam int ID_W     = 14;
	localparam int KEY_W    = 16;
	localparam int STATUS_W = 3;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
	localparam logic [OP_W-1:0] OP_PRED   = 3'd3;
	localparam logic [OP_W-1:0] OP_SUCC   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_NEIGHBOR = 3'd4;

	typedef struct packed {
		logic              link_we;
		logic [SLOT_W-1:0] link_addr;
		logic [LINK_W-1:0] link_data;
		logic              ent_we;
		logic [SLOT_W-1:0] ent_addr;
		logic [ID_W-1:0]   ent_id;
		logic [KEY_W-1:0]  ent_key;
	} sll_wr_t;

	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic [ID_W-1:0]   id;
		logic [KEY_W-1:0]  key;
	} sll_rd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [ID_W-1:0]     id;
		logic [KEY_W-1:0]    key;
		logic [LINK_W-1:0]   total;
	} sll_res_t;

	function automatic logic is_slot(input logic [LINK_W-1:0] s);
		return s < NIL;
	endfunction

endpackage

/* src/sll_store.sv */
module sll_store (
	input  logic            clk,
	input  logic            arst_n,
	input  sll_pkg::sll_wr_t wr,
	input  logic [sll_pkg::SLOT_W-1:0] rd_addr,
	output sll_pkg::sll_rd_t rd
);
	import sll_pkg::*;

	logic [LINK_W-1:0] link_q [CAPACITY];
	logic [ID_W-1:0]   ids_q  [CAPACITY];
	logic [KEY_W-1:0]  keys_q [CAPACITY];

	// free chain at reset: every slot points to the next one, last to null
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				link_q[i] <= LINK_W'(i + 1);
			end
		end else if (wr.link_we) begin
			link_q[wr.link_addr] <= wr.link_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.ent_we) begin
			ids_q[wr.ent_addr]  <= wr.ent_id;
			keys_q[wr.ent_addr] <= wr.ent_key;
		end
	end

	assign rd.link = link_q[rd_addr];
	assign rd.id   = ids_q[rd_addr];
	assign rd.key  = keys_q[rd_addr];

endmodule

/* src/sll_seq.sv */
module sll_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sll_pkg::OP_W-1:0]    in_op,
	input  logic [sll_pkg::ID_W-1:0]    in_id,
	input  logic [sll_pkg::KEY_W-1:0]   in_key,
	output logic                        res_valid,
	input  logic                        res_ready,
	output sll_pkg::sll_res_t           res,
	output sll_pkg::sll_wr_t            wr,
	output logic [sll_pkg::SLOT_W-1:0]  rd_addr,
	input  sll_pkg::sll_rd_t            rd
);
	import sll_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_WALK     = 3'd1;
	localparam logic [2:0] S_INS_LINK = 3'd2;
	localparam logic [2:0] S_REM_FREE = 3'd3;
	localparam logic [2:0] S_REPORT   = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [ID_W-1:0]     id_q;
	logic [KEY_W-1:0]    key_q;
	logic [LINK_W-1:0]   cur_q;
	logic [LINK_W-1:0]   prev_q;
	logic [LINK_W-1:0]   p_q;
	logic [LINK_W-1:0]   steps_q;
	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   tail_q;
	logic [LINK_W-1:0]   free_q;
	logic [LINK_W-1:0]   count_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   rslot_q;
	logic [ID_W-1:0]     rid_q;
	logic [KEY_W-1:0]    rkey_q;

	logic              accept;
	logic              cont;
	logic              walk_more;
	logic              id_hit;
	logic [LINK_W-1:0] cur_eff;
	logic [LINK_W-1:0] after;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);

	// shared compare: key ordering on insert, id match on every other op
	assign id_hit    = (rd.id == id_q);
	assign cont      = (op_q == OP_INSERT) ? (key_q < rd.key) : !id_hit;
	assign walk_more = is_slot(cur_q) && (steps_q < NIL) && cont;
	assign cur_eff   = is_slot(cur_q) ? cur_q : NIL;
	assign after     = is_slot(rd.link) ? rd.link : NIL;

	always_comb begin
		unique case (state_q) inside
			S_IDLE:   rd_addr = free_q[SLOT_W-1:0];
			S_REPORT,
			S_REM_FREE,
			S_INS_LINK: rd_addr = p_q[SLOT_W-1:0];
			default:  rd_addr = cur_q[SLOT_W-1:0];
		endcase
	end

	always_comb begin
		wr = '0;
		wr.ent_addr = free_q[SLOT_W-1:0];
		wr.ent_id   = in_id;
		wr.ent_key  = in_key;
		wr.ent_we   = accept && (in_op == OP_INSERT) && is_slot(free_q);
		unique case (state_q)
			S_WALK: begin
				if (!walk_more) begin
					if (op_q == OP_INSERT) begin
						wr.link_we   = 1'b1;
						wr.link_addr = p_q[SLOT_W-1:0];
						wr.link_data = cur_eff;
					end else if (op_q == OP_REMOVE && is_slot(cur_q) && id_hit
						&& is_slot(prev_q)) begin
						wr.link_we   = 1'b1;
						wr.link_addr = prev_q[SLOT_W-1:0];
						wr.link_data = after;
					end
				end
			end
			S_INS_LINK: begin
				wr.link_we   = 1'b1;
				wr.link_addr = prev_q[SLOT_W-1:0];
				wr.link_data = p_q;
			end
			S_REM_FREE: begin
				wr.link_we   = 1'b1;
				wr.link_addr = p_q[SLOT_W-1:0];
				wr.link_data = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NIL;
			tail_q  <= NIL;
			free_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_op == OP_INSERT) begin
							if (is_slot(free_q)) begin
								free_q  <= rd.link;
								state_q <= S_WALK;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							state_q <= is_slot(head_q) ? S_WALK : S_DONE;
						end
					end
				end
				S_WALK: begin
					if (!walk_more) begin
						if (op_q == OP_INSERT) begin
							if (!is_slot(cur_q)) tail_q <= p_q;
							count_q <= count_q + 1'b1;
							if (is_slot(prev_q)) begin
								state_q <= S_INS_LINK;
							end else begin
								head_q  <= p_q;
								state_q <= S_DONE;
							end
						end else if (is_slot(cur_q) && id_hit) begin
							unique case (op_q)
								OP_REMOVE: begin
									if (!is_slot(prev_q)) head_q <= after;
									if (cur_q == tail_q || !is_slot(after)) tail_q <= prev_q;
									if (count_q != '0) count_q <= count_q - 1'b1;
									state_q <= S_REM_FREE;
								end
								OP_PRED: state_q <= is_slot(prev_q) ? S_REPORT : S_DONE;
								OP_SUCC: state_q <= is_slot(rd.link) ? S_REPORT : S_DONE;
								default: state_q <= S_DONE;
							endcase
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INS_LINK: state_q <= S_DONE;
				S_REM_FREE: begin
					free_q  <= p_q;
					state_q <= S_DONE;
				end
				S_REPORT: state_q <= S_DONE;
				S_DONE: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk pointers and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= in_op;
					id_q    <= in_id;
					key_q   <= in_key;
					cur_q   <= head_q;
					prev_q  <= NIL;
					steps_q <= '0;
					p_q     <= free_q;
					rslot_q <= '0;
					rid_q   <= '0;
					rkey_q  <= '0;
					if (in_op == OP_INSERT) status_q <= is_slot(free_q) ? ST_OK : ST_FULL;
					else status_q <= is_slot(head_q) ? ST_OK : ST_EMPTY;
				end
			end
			S_WALK: begin
				if (walk_more) begin
					prev_q  <= cur_q;
					cur_q   <= rd.link;
					steps_q <= steps_q + 1'b1;
				end else if (op_q == OP_INSERT) begin
					rslot_q <= p_q[SLOT_W-1:0];
					rid_q   <= id_q;
					rkey_q  <= key_q;
				end else if (!(is_slot(cur_q) && id_hit)) begin
					status_q <= ST_NOT_FOUND;
				end else begin
					unique case (op_q)
						OP_PRED: begin
							if (is_slot(prev_q)) p_q <= prev_q;
							else status_q <= ST_NO_NEIGHBOR;
						end
						OP_SUCC: begin
							if (is_slot(rd.link)) p_q <= rd.link;
							else status_q <= ST_NO_NEIGHBOR;
						end
						default: begin
							p_q     <= cur_q;
							rslot_q <= cur_q[SLOT_W-1:0];
							rid_q   <= rd.id;
							rkey_q  <= rd.key;
						end
					endcase
				end
			end
			S_REPORT: begin
				rslot_q <= p_q[SLOT_W-1:0];
				rid_q   <= rd.id;
				rkey_q  <= rd.key;
			end
			default: ;
		endcase
	end

	assign res.status = status_q;
	assign res.slot   = rslot_q;
	assign res.id     = rid_q;
	assign res.key    = rkey_q;
	assign res.total  = count_q;

endmodule

/* src/sorted_static_linked_list.sv */
// Channel   Dir  tdata (low bit first)                              tuser
// s_axis    in   sector_id[13:0], key[29:14], zero pad to 32        op[2:0]
// m_axis    out  slot[3:0], found_id[17:4], found_key[33:18],       status[2:0]
//                entry_total[38:34], zero pad to 40
//
// One operation walks the list one slot per cycle through a single read port of the
// slot store.
// Reset leaves the list empty with all slots on the free chain; no clearing pass.
// Input is taken only between operations; a finished result waits in the output
// register, and the next operation may start while it is held.
module sorted_static_linked_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sector_id, key
	input  logic [2:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // slot, found_id, found_key, entry_total
	output logic [2:0]  m_axis_tuser   // status
);
	import sll_pkg::*;

	sll_wr_t           wr;
	sll_rd_t           rd;
	sll_res_t          res;
	logic [SLOT_W-1:0] rd_addr;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;
	sll_res_t          out_q;

	sll_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	sll_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_id     (s_axis_tdata[ID_W-1:0]),
		.in_key    (s_axis_tdata[ID_W+KEY_W-1:ID_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd        (rd)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {1'b0, out_q.total, out_q.key, out_q.id, out_q.slot};

endmodule
